FILE: hdl/mdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared types, widths and helpers for the HI/LO multiply/divide unit.
// ----------------------------------------------------------------------------
package mdu_pkg;

   localparam int DATA_W   = 64;
   localparam int WORD_W   = 32;
   localparam int OP_W     = 4;
   localparam int CNT_W    = $clog2(DATA_W);
   localparam int ADD_IN_W = DATA_W + 1;
   localparam int ADD_W    = DATA_W + 2;

   // request tdata: opcode, operand_a, operand_b, padded to whole bytes
   localparam int REQ_BITS = OP_W + 2 * DATA_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = 3 * DATA_W;

   typedef enum logic [OP_W-1:0] {
      OP_MULT   = 4'd0,
      OP_MULTU  = 4'd1,
      OP_DMULT  = 4'd2,
      OP_DMULTU = 4'd3,
      OP_DIV    = 4'd4,
      OP_DIVU   = 4'd5,
      OP_DDIV   = 4'd6,
      OP_DDIVU  = 4'd7,
      OP_MFHI   = 4'd8,
      OP_MFLO   = 4'd9,
      OP_MTHI   = 4'd10,
      OP_MTLO   = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_A,
      ST_PREP_B,
      ST_ITER,
      ST_FIX_1,
      ST_FIX_2,
      ST_DONE
   } state_type;

   function automatic logic [DATA_W-1:0] sext32(input logic [WORD_W-1:0] v);
      sext32 = {{(DATA_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] zext32(input logic [WORD_W-1:0] v);
      zext32 = {{(DATA_W-WORD_W){1'b0}}, v};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mips64_multiply_divide_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips64_multiply_divide_unit
// HI/LO multiply/divide unit built around one shared 66-bit add/subtract
// unit: shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  req_    | in  | opcode[3:0], operand_a[67:4], operand_b[131:68], pad
//  rsp_    | out | result_value[63:0], hi_after[127:64], lo_after[191:128]
//
//  Multiplies and divides step through operand prep (ST_PREP_A, ST_PREP_B), one
//  shared-adder iteration per operand bit, fixup (ST_FIX_1, ST_FIX_2) and
//  writeback; moves and unused opcodes go straight to writeback. req_tready is
//  high only while idle, so no request is taken until the last is written back.
//  Writeback waits while the output register still holds an untaken result.
//  Reset (synchronous, active high) clears HI, LO, the sequencer and rsp_tvalid.
// ----------------------------------------------------------------------------
module mips64_multiply_divide_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // opcode, operand_a, operand_b, zero pad
   input  wire logic [mdu_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // result_value, hi_after, lo_after
   output logic [mdu_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int DW = mdu_pkg::DATA_W;
   localparam int WW = mdu_pkg::WORD_W;
   localparam int AI = mdu_pkg::ADD_IN_W;
   localparam int AW = mdu_pkg::ADD_W;
   localparam int CW = mdu_pkg::CNT_W;

   mdu_pkg::state_type state_ff, state_in;
   mdu_pkg::op_type    op_ff, op_in;
   logic [DW-1:0]      a_ff, a_in;
   logic [DW-1:0]      b_ff, b_in;
   logic [DW-1:0]      acc_hi_ff, acc_hi_in;
   logic [DW-1:0]      acc_lo_ff, acc_lo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               neg_q_ff, neg_q_in;
   logic               neg_r_ff, neg_r_in;
   logic [DW-1:0]      hi_ff, hi_in;
   logic [DW-1:0]      lo_ff, lo_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [mdu_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // shared adder
   logic [AI-1:0] add_x, add_y;
   logic          add_sub;
   logic [AW-1:0] add_sum;

   // decode
   mdu_pkg::op_type req_op;
   logic [DW-1:0]   req_a, req_b, ext_a, ext_b;
   logic            is_word, is_sext, is_sdiv_req;
   logic            is_div, is_sdiv, is_dmult;
   logic [AI-1:0]   trial, step;
   logic [DW-1:0]   new_hi, new_lo, result;
   logic            out_free;

   assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {AW{add_sub}}) + AW'(add_sub);

   assign req_tready = (state_ff == mdu_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      req_op = mdu_pkg::op_type'(req_tdata[mdu_pkg::OP_W-1:0]);
      req_a  = req_tdata[mdu_pkg::OP_W +: DW];
      req_b  = req_tdata[mdu_pkg::OP_W + DW +: DW];

      is_word     = (req_op == mdu_pkg::OP_MULT) || (req_op == mdu_pkg::OP_MULTU) ||
                    (req_op == mdu_pkg::OP_DIV)  || (req_op == mdu_pkg::OP_DIVU);
      is_sext     = (req_op == mdu_pkg::OP_MULT) || (req_op == mdu_pkg::OP_DIV);
      is_sdiv_req = (req_op == mdu_pkg::OP_DIV)  || (req_op == mdu_pkg::OP_DDIV);

      ext_a = req_a;
      ext_b = req_b;
      if (is_word) begin
         ext_a = is_sext ? mdu_pkg::sext32(req_a[WW-1:0]) : mdu_pkg::zext32(req_a[WW-1:0]);
         ext_b = is_sext ? mdu_pkg::sext32(req_b[WW-1:0]) : mdu_pkg::zext32(req_b[WW-1:0]);
      end

      is_div   = (op_ff == mdu_pkg::OP_DIV)  || (op_ff == mdu_pkg::OP_DIVU) ||
                 (op_ff == mdu_pkg::OP_DDIV) || (op_ff == mdu_pkg::OP_DDIVU);
      is_sdiv  = (op_ff == mdu_pkg::OP_DIV)  || (op_ff == mdu_pkg::OP_DDIV);
      is_dmult = (op_ff == mdu_pkg::OP_DMULT);

      trial = {acc_hi_ff, acc_lo_ff[DW-1]};
      step  = '0;

      out_free = !rsp_tvalid_ff || rsp_tready;

      // defaults
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      acc_hi_in     = acc_hi_ff;
      acc_lo_in     = acc_lo_ff;
      cnt_in        = cnt_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      add_x         = '0;
      add_y         = '0;
      add_sub       = 1'b0;

      // writeback values
      new_hi = hi_ff;
      new_lo = lo_ff;
      result = '0;
      case (op_ff)
         mdu_pkg::OP_MULT, mdu_pkg::OP_MULTU: begin
            new_lo = mdu_pkg::sext32(acc_lo_ff[WW-1:0]);
            new_hi = mdu_pkg::sext32(acc_lo_ff[DW-1:WW]);
         end
         mdu_pkg::OP_DIV, mdu_pkg::OP_DIVU: begin
            new_lo = mdu_pkg::sext32(acc_lo_ff[WW-1:0]);
            new_hi = mdu_pkg::sext32(acc_hi_ff[WW-1:0]);
         end
         mdu_pkg::OP_DMULT, mdu_pkg::OP_DMULTU,
         mdu_pkg::OP_DDIV, mdu_pkg::OP_DDIVU: begin
            new_lo = acc_lo_ff;
            new_hi = acc_hi_ff;
         end
         mdu_pkg::OP_MFHI: result = hi_ff;
         mdu_pkg::OP_MFLO: result = lo_ff;
         mdu_pkg::OP_MTHI: new_hi = a_ff;
         mdu_pkg::OP_MTLO: new_lo = a_ff;
         default: ;
      endcase

      case (state_ff)
         mdu_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_op;
               a_in      = ext_a;
               b_in      = ext_b;
               acc_hi_in = '0;
               acc_lo_in = ext_b;
               cnt_in    = '0;
               neg_q_in  = is_sdiv_req && (ext_a[DW-1] ^ ext_b[DW-1]);
               neg_r_in  = is_sdiv_req && ext_a[DW-1];
               if (req_tdata[mdu_pkg::OP_W-1] == 1'b0)
                  state_in = mdu_pkg::ST_PREP_A;
               else
                  state_in = mdu_pkg::ST_DONE;
            end
         end
         mdu_pkg::ST_PREP_A: begin
            // dividend magnitude goes into the quotient shift register
            add_y   = {1'b0, a_ff};
            add_sub = 1'b1;
            if (is_div)
               acc_lo_in = (is_sdiv && a_ff[DW-1]) ? add_sum[DW-1:0] : a_ff;
            state_in = mdu_pkg::ST_PREP_B;
         end
         mdu_pkg::ST_PREP_B: begin
            add_y   = {1'b0, b_ff};
            add_sub = 1'b1;
            if (is_sdiv && b_ff[DW-1])
               b_in = add_sum[DW-1:0];
            state_in = mdu_pkg::ST_ITER;
         end
         mdu_pkg::ST_ITER: begin
            if (is_div) begin
               // restoring step: subtract divisor from shifted remainder
               add_x     = trial;
               add_y     = {1'b0, b_ff};
               add_sub   = 1'b1;
               step      = add_sum[AW-1] ? trial : add_sum[AI-1:0];
               acc_hi_in = step[DW-1:0];
               acc_lo_in = {acc_lo_ff[DW-2:0], ~add_sum[AW-1]};
            end else begin
               add_x     = {1'b0, acc_hi_ff};
               add_y     = {1'b0, a_ff};
               step      = acc_lo_ff[0] ? add_sum[AI-1:0] : {1'b0, acc_hi_ff};
               acc_hi_in = step[AI-1:1];
               acc_lo_in = {step[0], acc_lo_ff[DW-1:1]};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1))
               state_in = mdu_pkg::ST_FIX_1;
         end
         mdu_pkg::ST_FIX_1: begin
            add_sub = 1'b1;
            if (is_div) begin
               add_y = {1'b0, acc_lo_ff};
               if (neg_q_ff)
                  acc_lo_in = add_sum[DW-1:0];
            end else begin
               // signed 128-bit product: hi -= b when a is negative
               add_x = {1'b0, acc_hi_ff};
               add_y = {1'b0, b_ff};
               if (is_dmult && a_ff[DW-1])
                  acc_hi_in = add_sum[DW-1:0];
            end
            state_in = mdu_pkg::ST_FIX_2;
         end
         mdu_pkg::ST_FIX_2: begin
            add_sub = 1'b1;
            if (is_div) begin
               add_y = {1'b0, acc_hi_ff};
               if (neg_r_ff)
                  acc_hi_in = add_sum[DW-1:0];
            end else begin
               add_x = {1'b0, acc_hi_ff};
               add_y = {1'b0, a_ff};
               if (is_dmult && b_ff[DW-1])
                  acc_hi_in = add_sum[DW-1:0];
            end
            state_in = mdu_pkg::ST_DONE;
         end
         mdu_pkg::ST_DONE: begin
            if (out_free) begin
               hi_in         = new_hi;
               lo_in         = new_lo;
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {new_lo, new_hi, result};
               state_in      = mdu_pkg::ST_IDLE;
            end
         end
         default: state_in = mdu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mdu_pkg::ST_IDLE;
         hi_ff         <= '0;
         lo_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hi_ff         <= hi_in;
         lo_ff         <= lo_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_hi_ff   <= acc_hi_in;
      acc_lo_ff   <= acc_lo_in;
      cnt_ff      <= cnt_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
